/* hdl/gffra_pkg.sv */
// ============================================================================
// Grid first-fit allocator package
// Shared sizes, payload structs, memory request and sequencer state types.
// ============================================================================
package gffra_pkg;

    // Largest grid the storage supports.
    localparam int MAX_COLS = 16;
    localparam int MAX_ROWS = 16;

    // Fixed field widths.
    localparam int DIM_W = 5;
    localparam int POS_W = 4;

    // Index widths into a row and into the row store.
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // Counters must hold any field value and the grid maximum itself.
    localparam int CNT_MAX = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int CNT_W   = ($clog2(CNT_MAX + 1) > DIM_W) ? $clog2(CNT_MAX + 1) : DIM_W;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_IDX_LSB = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;
    localparam logic [DIM_W-1:0]     GRID_DIM_RESET = 5'd16;

    // Item actions.
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_PLACE = 1'b1;

    typedef logic [MAX_COLS-1:0] row_bits_t;

    typedef struct packed {
        logic             action;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic             placed;
        logic [POS_W-1:0] place_col;
        logic [POS_W-1:0] place_row;
    } out_item_t;

    // Grid size in use, already saturated to the storage limits.
    typedef struct packed {
        logic [CNT_W-1:0] cols;
        logic [CNT_W-1:0] rows;
    } grid_dims_t;

    // Request from the sequencer to the occupancy store.
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        row_bits_t        wr_data;
        logic             clear_all;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WAIT,
        ST_SEARCH,
        ST_WR_RD,
        ST_WR_WR,
        ST_DONE
    } seq_state_t;

endpackage

/* hdl/gffra_cfg.sv */
// ============================================================================
// Grid first-fit allocator configuration registers
// Holds the grid size written over the register port and saturates it.
// ============================================================================
module gffra_cfg
    import gffra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output grid_dims_t            dims
);

    logic [DIM_W-1:0]     grid_cols_reg;
    logic [DIM_W-1:0]     grid_rows_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_fire;

    assign reg_idx = paddr[CFG_IDX_LSB +: CFG_IDX_W];
    assign wr_fire = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_DIM_RESET;
            grid_rows_reg <= GRID_DIM_RESET;
        end
        else if (wr_fire)
        begin
            unique case (reg_idx)
                REG_GRID_COLS: grid_cols_reg <= pwdata[DIM_W-1:0];
                REG_GRID_ROWS: grid_rows_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_COLS: prdata = CFG_DATA_W'(grid_cols_reg);
            REG_GRID_ROWS: prdata = CFG_DATA_W'(grid_rows_reg);
            default:       prdata = '0;
        endcase
    end

    // Sizes beyond the storage are clamped to the storage.
    always_comb
    begin
        dims.cols = (CNT_W'(grid_cols_reg) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                                : CNT_W'(grid_cols_reg);
        dims.rows = (CNT_W'(grid_rows_reg) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                                : CNT_W'(grid_rows_reg);
    end

endmodule

/* hdl/gffra_occ_mem.sv */
// ============================================================================
// Grid first-fit allocator occupancy store
// One row of cells per entry, registered read, per-row valid bits for clear.
// ============================================================================
module gffra_occ_mem
    import gffra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mem_req_t  req,
    output row_bits_t rdata
);

    row_bits_t             mem [MAX_ROWS];
    row_bits_t             rd_data_reg;
    logic                  rd_valid_reg;
    logic [MAX_ROWS-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // A row that was never written since the last clear reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hdl/gffra_ctrl.sv */
// ============================================================================
// Grid first-fit allocator sequencer
// Scans start rows, merges the covered rows, searches columns, then marks.
// ============================================================================
module gffra_ctrl
    import gffra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    input  grid_dims_t dims,
    output mem_req_t   mem_req,
    input  row_bits_t  mem_rdata
);

    localparam int SUM_W = CNT_W + 1;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] k_reg, k_next;
    row_bits_t        acc_reg, acc_next;
    row_bits_t        span_reg, span_next;
    logic [DIM_W-1:0] w_reg, w_next;
    logic [DIM_W-1:0] h_reg, h_next;
    out_item_t        res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             accept;
    logic             early_fail;
    logic             out_free;
    logic             k_last;
    logic             next_r_ok;
    logic [CNT_W-1:0] row_addr;
    logic             fit_found;
    logic [COL_W-1:0] fit_col;
    row_bits_t        fit_span;

    // Cells covered by a run of w columns starting at column c.
    function automatic row_bits_t window_mask(input logic [DIM_W-1:0] w,
                                              input logic [COL_W-1:0] c);
        row_bits_t m;
        if (SUM_W'(w) >= SUM_W'(MAX_COLS))
        begin
            m = '1;
        end
        else
        begin
            m = (row_bits_t'(1) << w) - row_bits_t'(1);
        end
        return m << c;
    endfunction

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign k_last     = (SUM_W'(k_reg) + SUM_W'(1) == SUM_W'(h_reg));
    assign next_r_ok  = (SUM_W'(r_reg) + SUM_W'(1) + SUM_W'(h_reg) <= SUM_W'(dims.rows));
    assign row_addr   = r_reg + k_reg;
    assign early_fail = (dims.cols == '0) || (dims.rows == '0)
                     || (SUM_W'(in_data.rect_width) > SUM_W'(dims.cols))
                     || (SUM_W'(in_data.rect_height) > SUM_W'(dims.rows));

    // Lowest start column whose window stays inside the grid and is free.
    always_comb
    begin
        row_bits_t win;
        fit_found = 1'b0;
        fit_col   = '0;
        fit_span  = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--)
        begin
            win = window_mask(w_reg, COL_W'(c));
            if ((SUM_W'(c) + SUM_W'(w_reg) <= SUM_W'(dims.cols)) && ((acc_reg & win) == '0))
            begin
                fit_found = 1'b1;
                fit_col   = COL_W'(c);
                fit_span  = win;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.action == ACT_CLEAR || early_fail)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (in_data.rect_height == '0)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_ACC_RD;
                    end
                end
            end
            ST_ACC_RD:   state_next = ST_ACC_WAIT;
            ST_ACC_WAIT: state_next = k_last ? ST_SEARCH : ST_ACC_RD;
            ST_SEARCH:
            begin
                if (fit_found)
                begin
                    state_next = (h_reg == '0) ? ST_DONE : ST_WR_RD;
                end
                else if (next_r_ok)
                begin
                    state_next = (h_reg == '0) ? ST_SEARCH : ST_ACC_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WR_RD:    state_next = ST_WR_WR;
            ST_WR_WR:    state_next = k_last ? ST_DONE : ST_WR_RD;
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory requests.
    always_comb
    begin
        r_next         = r_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        span_next      = span_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mem_req        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    w_next            = in_data.rect_width;
                    h_next            = in_data.rect_height;
                    r_next            = '0;
                    k_next            = '0;
                    acc_next          = '0;
                    res_next          = '0;
                    res_next.placed   = (in_data.action == ACT_CLEAR);
                    mem_req.clear_all = (in_data.action == ACT_CLEAR);
                end
            end
            ST_ACC_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_addr[ROW_W-1:0];
            end
            ST_ACC_WAIT:
            begin
                acc_next = acc_reg | mem_rdata;
                k_next   = k_reg + CNT_W'(1);
            end
            ST_SEARCH:
            begin
                k_next = '0;
                if (fit_found)
                begin
                    span_next          = fit_span;
                    res_next.placed    = 1'b1;
                    res_next.place_col = POS_W'(fit_col);
                    res_next.place_row = POS_W'(r_reg);
                end
                else
                begin
                    r_next   = r_reg + CNT_W'(1);
                    acc_next = '0;
                end
            end
            ST_WR_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_addr[ROW_W-1:0];
            end
            ST_WR_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_addr[ROW_W-1:0];
                mem_req.wr_data = mem_rdata | span_reg;
                k_next          = k_reg + CNT_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        span_reg     <= span_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/grid_first_fit_rect_allocator_top.sv */
// ============================================================================
// Grid first-fit rectangle allocator
// Places rectangles first-fit into an occupancy bitmap of a configurable grid.
// ============================================================================
// A clear, or a place that cannot fit the grid at all, goes straight to the done state,
// which loads the output register once it is free. Any other place merges the h rows
// under each start row tried, searches the merged row, then read-modify-writes the h
// chosen rows. Each row read has a wait state since the store has a registered read.
// Throughput: one item in work at a time; the next transfer can be taken in the cycle
// after a result enters the output register. Reset empties the grid, sizes it to 16 by 16.
module grid_first_fit_rect_allocator_top
    import gffra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    grid_dims_t dims;
    mem_req_t   mem_req;
    row_bits_t  mem_rdata;

    // Grid size registers; the sequencer sees the clamped size.
    gffra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // The sequencer merges the rows under each start row, searches the
    // merged row for the first free window, then read-modify-writes the
    // covered rows. It owns the output register, so a finished result can
    // wait for the consumer while the next input transfer is taken.
    gffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .dims      (dims),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // Occupancy bitmap, one grid row per entry.
    gffra_occ_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // A failed placement reports the origin as its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.placed) |->
            (out_data.place_col == '0 && out_data.place_row == '0))
        else $error("failed placement carries a nonzero position");

    // Once an item is taken, the input side is held off in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again before the item was worked off");

    // A placed rectangle starts inside the grid in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.placed) |->
            (CNT_W'(out_data.place_col) < dims.cols || out_data.place_col == '0))
        else $error("placement column outside the grid");

    // Marking happens only while an item is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> in_stall)
        else $error("occupancy written while idle");

endmodule
